// ===== rtl/lfc_pkg.sv =====
package lfc_pkg;

  localparam int unsigned ID_W      = 11;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned LUX_W     = 24;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned AGE_W     = 17;
  localparam int unsigned SUM_W     = 11;
  localparam int unsigned CHK_W     = 16;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [LEN_W-1:0]     GOOD_LENGTH     = 4'd8;
  localparam logic [7:0]           GOOD_STATUS     = 8'h00;
  localparam logic [LUX_W-1:0]     HIGH_LUX_AT     = 24'd200000;
  localparam logic [AGE_W-1:0]     AGE_MAX         = 17'h1FFFF;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd1000;

  typedef enum logic [2:0] {
    OUT_TICK     = 3'd0,
    OUT_ACCEPTED = 3'd1,
    OUT_WRONG_ID = 3'd2,
    OUT_BAD_LEN  = 3'd3,
    OUT_STATUS   = 3'd4,
    OUT_CHECKSUM = 3'd5
  } outcome_t;

  typedef enum logic {
    REG_FRAME_ID      = 1'b0,
    REG_STALE_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_FRAME = 1'b1
  } action_t;

  typedef struct packed {
    logic [ID_W-1:0]      frame_id;
    logic [TIMEOUT_W-1:0] stale_timeout;
  } cfg_t;

  typedef struct packed {
    action_t             action;
    logic [ID_W-1:0]     rx_id;
    logic [LEN_W-1:0]    rx_length;
    logic [DATA_W-1:0]   rx_data;
  } item_t;

  typedef struct packed {
    logic            lux_valid;
    logic [LUX_W-1:0] lux;
    outcome_t        outcome;
    logic            stale;
    logic            high_lux;
  } result_t;

endpackage

// ===== rtl/lfc_cfg_regs.sv =====
module lfc_cfg_regs import lfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [ID_W-1:0]      frame_id_r, frame_id_nxt;
  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic                 wr_en;
  reg_idx_t             idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  // word address, byte offset ignored
  assign idx    = reg_idx_t'(paddr[2]);

  always_comb begin
    frame_id_nxt = frame_id_r;
    timeout_nxt  = timeout_r;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_ID:      frame_id_nxt = pwdata[ID_W-1:0];
        REG_STALE_TIMEOUT: timeout_nxt  = pwdata[TIMEOUT_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_ID:      prdata = {{(PDATA_W-ID_W){1'b0}}, frame_id_r};
      REG_STALE_TIMEOUT: prdata = {{(PDATA_W-TIMEOUT_W){1'b0}}, timeout_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r <= '0;
      timeout_r  <= TIMEOUT_RESET;
    end else begin
      frame_id_r <= frame_id_nxt;
      timeout_r  <= timeout_nxt;
    end
  end

  assign cfg.frame_id      = frame_id_r;
  assign cfg.stale_timeout = timeout_r;

endmodule

// ===== rtl/lfc_eval.sv =====
module lfc_eval import lfc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    take,
  output result_t res
);

  logic [LUX_W-1:0] held_lux_r, held_lux_nxt;
  logic             have_r, have_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;

  logic [SUM_W-1:0] sum;
  logic [CHK_W-1:0] check;
  logic [LUX_W-1:0] new_lux;
  logic [7:0]       status;
  outcome_t         outcome;
  logic             suppress;
  logic             lux_valid;

  assign sum = {3'b0, item.rx_data[7:0]}   + {3'b0, item.rx_data[15:8]}
             + {3'b0, item.rx_data[23:16]} + {3'b0, item.rx_data[31:24]}
             + {3'b0, item.rx_data[39:32]} + {3'b0, item.rx_data[47:40]};
  assign check   = item.rx_data[63:48];
  assign new_lux = item.rx_data[23:0];
  assign status  = item.rx_data[31:24];

  always_comb begin
    suppress = 1'b0;
    priority if (item.action == ACT_TICK) begin
      outcome = OUT_TICK;
    end else if (item.rx_id != cfg.frame_id) begin
      outcome = OUT_WRONG_ID;
    end else if (item.rx_length != GOOD_LENGTH) begin
      outcome = OUT_BAD_LEN;
    end else if (status != GOOD_STATUS) begin
      outcome  = OUT_STATUS;
      suppress = 1'b1;
    end else if ({{(CHK_W-SUM_W){1'b0}}, sum} != check) begin
      outcome = OUT_CHECKSUM;
    end else begin
      outcome = OUT_ACCEPTED;
    end
  end

  always_comb begin
    held_lux_nxt = held_lux_r;
    have_nxt     = have_r;
    age_nxt      = age_r;
    if (outcome == OUT_ACCEPTED) begin
      held_lux_nxt = new_lux;
      have_nxt     = 1'b1;
      age_nxt      = '0;
    end else if (outcome == OUT_TICK && age_r != AGE_MAX) begin
      age_nxt = age_r + 1'b1;
    end
  end

  assign lux_valid     = have_nxt && !suppress;
  assign res.lux_valid = lux_valid;
  assign res.lux       = lux_valid ? held_lux_nxt : '0;
  assign res.outcome   = outcome;
  assign res.stale     = age_nxt > {1'b0, cfg.stale_timeout};
  assign res.high_lux  = (outcome == OUT_ACCEPTED) && (new_lux > HIGH_LUX_AT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lux_r <= '0;
      have_r     <= 1'b0;
      age_r      <= '0;
    end else if (take) begin
      held_lux_r <= held_lux_nxt;
      have_r     <= have_nxt;
      age_r      <= age_nxt;
    end
  end

endmodule

// ===== rtl/can_light_frame_checker_core.sv =====
// Light sensor CAN frame checker. Each request is either a one-millisecond tick
// (in_action = 0) or a received frame (in_action = 1), and gives exactly one
// result in request order. A frame is accepted when its identifier matches
// frame_id, its length code is 8, status byte 3 is zero and the 11-bit sum of
// bytes 0..5 equals the little-endian checksum in bytes 6..7; its 24-bit lux
// (bytes 0..2) is then held and the millisecond age is cleared. A status error
// reports no lux. One request is taken every cycle unless the output stalls;
// the request register feeds the id/length/status compares and the six-byte
// checksum adder, and the outcome is captured in the result register. Registers:
// frame_id at byte address 0, stale_timeout at byte address 4 (reset 1000);
// write them only while no request is in flight.
module can_light_frame_checker_core import lfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [ID_W-1:0]    in_rx_id,
  input  logic [LEN_W-1:0]   in_rx_length,
  input  logic [DATA_W-1:0]  in_rx_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_lux_valid,
  output logic [LUX_W-1:0]   out_lux,
  output logic [2:0]         out_outcome,
  output logic               out_stale,
  output logic               out_high_lux,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t    cfg;
  item_t   item_r;
  logic    req_valid_r, req_valid_nxt;
  result_t res, res_r;
  logic    res_valid_r, res_valid_nxt;
  logic    in_take, adv;

  lfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfc_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (item_r),
    .take  (adv),
    .res   (res)
  );

  // request moves on when the result register is free or being emptied
  assign adv      = req_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = req_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_take) begin
      req_valid_nxt = 1'b1;
    end else if (adv) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (adv) begin
      res_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action    <= action_t'(in_action);
      item_r.rx_id     <= in_rx_id;
      item_r.rx_length <= in_rx_length;
      item_r.rx_data   <= in_rx_data;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid     = res_valid_r;
  assign out_lux_valid = res_r.lux_valid;
  assign out_lux       = res_r.lux;
  assign out_outcome   = res_r.outcome;
  assign out_stale     = res_r.stale;
  assign out_high_lux  = res_r.high_lux;

endmodule

// ===== rtl/lfc_checker.sv =====
module lfc_checker import lfc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_lux_valid,
  input logic [LUX_W-1:0] out_lux,
  input logic [2:0]       out_outcome,
  input logic             out_stale,
  input logic             out_high_lux
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // status error never reports a reading
  a_status_no_lux: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_STATUS |-> !out_lux_valid && out_lux == '0)
    else $error("status error reported a lux value");

  a_no_lux_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lux_valid |-> out_lux == '0)
    else $error("lux not zero without a reading");

  a_high_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_lux |-> out_outcome == OUT_ACCEPTED && out_lux_valid
                                  && out_lux > HIGH_LUX_AT)
    else $error("high lux flag on a frame that was not accepted");

  // an accepted frame resets the age, so it is never stale
  a_accepted_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_ACCEPTED |-> !out_stale && out_lux_valid)
    else $error("accepted frame reported stale");

endmodule

bind can_light_frame_checker_core lfc_checker u_lfc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_lux_valid (out_lux_valid),
  .out_lux       (out_lux),
  .out_outcome   (out_outcome),
  .out_stale     (out_stale),
  .out_high_lux  (out_high_lux)
);
